// ===== hdl/solar_dusk_light_ramp_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dusk light ramp
// Same-cycle and next-cycle implication checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SOLAR_DUSK_LIGHT_RAMP_ASSERT_SVH
`define SOLAR_DUSK_LIGHT_RAMP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SDLR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SDLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sdlr_pkg.sv =====
// ----------------------------------------------------------------------------
// sdlr_pkg
// Register map, register widths and reset values of the dusk light ramp.
// ----------------------------------------------------------------------------
package sdlr_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register widths
    localparam int LIMIT_W  = 10;
    localparam int WEIGHT_W = 16;
    localparam int LEVEL_W  = 8;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DAYLIGHT_LIMIT   = 3'd0,
        REG_BATTERY_CUTOFF   = 3'd1,
        REG_SMOOTHING_WEIGHT = 3'd2,
        REG_MAX_LEVEL        = 3'd3,
        REG_RAMP_STEP        = 3'd4
    } cfg_index_t;

    // Reset values
    localparam logic [LIMIT_W-1:0]  DAYLIGHT_LIMIT_RST   = 10'd371;
    localparam logic [LIMIT_W-1:0]  BATTERY_CUTOFF_RST   = 10'd250;
    localparam logic [WEIGHT_W-1:0] SMOOTHING_WEIGHT_RST = 16'd655;
    localparam logic [LEVEL_W-1:0]  MAX_LEVEL_RST        = 8'd64;
    localparam logic [LEVEL_W-1:0]  RAMP_STEP_RST        = 8'd1;

endpackage

// ===== hdl/solar_dusk_light_ramp.sv =====
// ----------------------------------------------------------------------------
// solar_dusk_light_ramp
// Timing: an accepted request is captured in the input register, and its
// result in the result register when the input stage moves on.
// Throughput: one request per cycle unless the result is stalled by out_ready;
// the averaging loop (one multiply per channel feeding back into the average registers) is combinational.
// Reset: rst_n clears all valid bits, the averages, the light level and the
// primed flag, and loads the registers with their default values.
// ----------------------------------------------------------------------------
`include "solar_dusk_light_ramp_assert.svh"

module solar_dusk_light_ramp
    import sdlr_pkg::*;
#(
    parameter int SAMPLE_BITS   = 10,
    parameter int FRACTION_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    // Configuration write port
    input  logic                     cfg_we,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,

    // Sample request channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [SAMPLE_BITS-1:0]   solar_sample,
    input  logic [SAMPLE_BITS-1:0]   battery_sample,

    // Result channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [LEVEL_W-1:0]       light_duty,
    output logic [SAMPLE_BITS-1:0]   solar_average,
    output logic [SAMPLE_BITS-1:0]   battery_average,
    output logic                     daylight,
    output logic                     battery_low
);

    // Fixed-point average width, compare width, product width
    localparam int FILT_W = SAMPLE_BITS + FRACTION_BITS;
    localparam int CMP_W  = ((SAMPLE_BITS > LIMIT_W) ? SAMPLE_BITS : LIMIT_W) + FRACTION_BITS;
    localparam int PROD_W = FILT_W + WEIGHT_W + 2;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (WEIGHT_W - 1);

    // Configuration registers
    logic [LIMIT_W-1:0]   daylight_limit_reg;
    logic [LIMIT_W-1:0]   battery_cutoff_reg;
    logic [WEIGHT_W-1:0]  smoothing_weight_reg;
    logic [LEVEL_W-1:0]   max_level_reg;
    logic [LEVEL_W-1:0]   ramp_step_reg;

    // Input stage
    logic                     s1_valid_reg;
    logic [SAMPLE_BITS-1:0]   s1_solar_reg;
    logic [SAMPLE_BITS-1:0]   s1_battery_reg;

    // Filter and ramp state
    logic [FILT_W-1:0]    solar_filt_reg, solar_filt_next;
    logic [FILT_W-1:0]    battery_filt_reg, battery_filt_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic                 primed_reg;

    // Result stage
    logic                     out_valid_reg;
    logic [LEVEL_W-1:0]       light_duty_reg;
    logic [SAMPLE_BITS-1:0]   solar_avg_reg;
    logic [SAMPLE_BITS-1:0]   battery_avg_reg;
    logic                     daylight_reg, daylight_next;
    logic                     battery_low_reg, battery_low_next;

    logic                 s1_adv;
    logic [FILT_W-1:0]    solar_scaled;
    logic [FILT_W-1:0]    battery_scaled;
    logic [LEVEL_W:0]     level_sum;

    // avg + round((scaled - avg) * w / 65536), same as the weighted blend
    function automatic logic [FILT_W-1:0] smooth(
        input logic [FILT_W-1:0]   avg,
        input logic [FILT_W-1:0]   scaled,
        input logic [WEIGHT_W-1:0] w
    );
        logic signed [FILT_W:0]   diff;
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] shifted;
        diff    = $signed({1'b0, scaled}) - $signed({1'b0, avg});
        prod    = diff * $signed({1'b0, w}) + ROUND_HALF;
        shifted = prod >>> WEIGHT_W;
        return avg + shifted[FILT_W-1:0];
    endfunction

    // Handshake: the input stage moves on when the result register is free
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    // Scaled samples
    assign solar_scaled   = {s1_solar_reg, {FRACTION_BITS{1'b0}}};
    assign battery_scaled = {s1_battery_reg, {FRACTION_BITS{1'b0}}};

    // Averages, flags and light ramp
    always_comb
    begin
        if (primed_reg)
        begin
            solar_filt_next   = smooth(solar_filt_reg, solar_scaled, smoothing_weight_reg);
            battery_filt_next = smooth(battery_filt_reg, battery_scaled, smoothing_weight_reg);
        end
        else
        begin
            solar_filt_next   = solar_scaled;
            battery_filt_next = battery_scaled;
        end

        daylight_next    = CMP_W'(solar_filt_next)
                           > CMP_W'({daylight_limit_reg, {FRACTION_BITS{1'b0}}});
        battery_low_next = CMP_W'(battery_filt_next)
                           < CMP_W'({battery_cutoff_reg, {FRACTION_BITS{1'b0}}});

        level_sum = {1'b0, level_reg} + {1'b0, ramp_step_reg};
        if (daylight_next || battery_low_next)
            level_next = '0;
        else if (level_sum > {1'b0, max_level_reg})
            level_next = max_level_reg;
        else
            level_next = level_sum[LEVEL_W-1:0];
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            daylight_limit_reg   <= DAYLIGHT_LIMIT_RST;
            battery_cutoff_reg   <= BATTERY_CUTOFF_RST;
            smoothing_weight_reg <= SMOOTHING_WEIGHT_RST;
            max_level_reg        <= MAX_LEVEL_RST;
            ramp_step_reg        <= RAMP_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_DAYLIGHT_LIMIT:   daylight_limit_reg   <= cfg_data[LIMIT_W-1:0];
                REG_BATTERY_CUTOFF:   battery_cutoff_reg   <= cfg_data[LIMIT_W-1:0];
                REG_SMOOTHING_WEIGHT: smoothing_weight_reg <= cfg_data[WEIGHT_W-1:0];
                REG_MAX_LEVEL:        max_level_reg        <= cfg_data[LEVEL_W-1:0];
                REG_RAMP_STEP:        ramp_step_reg        <= cfg_data[LEVEL_W-1:0];
                default:              ;
            endcase
        end
    end

    // Control state: valid bits, filter state, level, primed flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            solar_filt_reg   <= '0;
            battery_filt_reg <= '0;
            level_reg        <= '0;
            primed_reg       <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s1_adv)
            begin
                out_valid_reg    <= 1'b1;
                solar_filt_reg   <= solar_filt_next;
                battery_filt_reg <= battery_filt_next;
                level_reg        <= level_next;
                primed_reg       <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_solar_reg   <= solar_sample;
            s1_battery_reg <= battery_sample;
        end
        if (s1_adv)
        begin
            light_duty_reg  <= level_next;
            solar_avg_reg   <= solar_filt_next[FILT_W-1:FRACTION_BITS];
            battery_avg_reg <= battery_filt_next[FILT_W-1:FRACTION_BITS];
            daylight_reg    <= daylight_next;
            battery_low_reg <= battery_low_next;
        end
    end

    // Outputs
    assign out_valid       = out_valid_reg;
    assign light_duty      = light_duty_reg;
    assign solar_average   = solar_avg_reg;
    assign battery_average = battery_avg_reg;
    assign daylight        = daylight_reg;
    assign battery_low     = battery_low_reg;

    // Checks
    `SDLR_ASSERT_SAME(a_duty_ceiling, clk, rst_n, out_valid_reg, light_duty_reg <= max_level_reg, "light duty above ceiling")
    `SDLR_ASSERT_SAME(a_forced_off, clk, rst_n, out_valid_reg && (daylight_reg || battery_low_reg), light_duty_reg == '0, "light on during cutoff")
    `SDLR_ASSERT_NEXT(a_primed_sticky, clk, rst_n, primed_reg, primed_reg, "primed flag dropped")
    `SDLR_ASSERT_NEXT(a_adv_result, clk, rst_n, s1_adv, out_valid_reg && primed_reg, "advanced request gave no result")

endmodule
